/* src/bleadv_pkg.sv */
// Shared types, constants and codes of the advertising duplicate filter.
package bleadv_pkg;

	localparam int MAX_DEVICES = 16;
	localparam int NAME_BYTES  = 32;
	localparam int NAME_ROOM   = NAME_BYTES - 1;
	localparam int SLOT_W      = $clog2(MAX_DEVICES);
	localparam int COUNT_W     = $clog2(MAX_DEVICES + 1);
	localparam int NPOS_W      = $clog2(NAME_BYTES);
	localparam int NAME_AW     = $clog2(MAX_DEVICES * NAME_ROOM);

	localparam logic [7:0] AD_SHORT_NAME = 8'h08;
	localparam logic [7:0] AD_FULL_NAME  = 8'h09;

	typedef enum logic [2:0] {
		ACT_START  = 3'd0,
		ACT_STOP   = 3'd1,
		ACT_HEADER = 3'd2,
		ACT_DATA   = 3'd3,
		ACT_READ   = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		ST_NEW      = 3'd0,
		ST_DUP      = 3'd1,
		ST_FULL     = 3'd2,
		ST_NOT_SCAN = 3'd3,
		ST_CTRL     = 3'd4,
		ST_READ     = 3'd5,
		ST_BAD_IDX  = 3'd6
	} status_t;

	typedef struct packed {
		logic [2:0]        action;
		logic [47:0]       device_address;
		logic signed [7:0] signal_strength;
		logic [7:0]        advert_kind;
		logic [7:0]        data_length;
		logic [7:0]        data_byte;
		logic [3:0]        entry_index;
	} in_item_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [3:0]        entry_slot;
		logic [4:0]        device_count;
		logic [47:0]       out_address;
		logic signed [7:0] out_strength;
		logic [7:0]        out_kind;
		logic [4:0]        name_length;
		logic [7:0]        name_byte;
		logic              last;
	} out_item_t;

endpackage

/* src/bleadv_if.sv */
// Valid/ready channel interfaces for input items and results.
interface bleadv_in_if import bleadv_pkg::*;;
	logic     valid;
	logic     ready;
	in_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

interface bleadv_out_if import bleadv_pkg::*;;
	logic      valid;
	logic      ready;
	out_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

/* src/ble_advert_dedup_table.sv */
// Advertising duplicate filter: device table, address search, name parser and read-out.
//
// The block takes items on the item channel and returns results on the result
// channel; both are valid/ready, and a transfer happens when valid and ready are
// high at a rising clock edge. Start, stop and report header items give one
// result each, advertising data bytes give none, and a read gives one result per
// stored name byte (one if the name is empty or the index is not stored).
// Data bytes are parsed in the cycle they transfer, so the block stays ready and
// takes one per cycle. A header searches the table with one shared address
// comparator, one stored entry at a time (memory read, then compare), and a new
// address then takes a table write before its result; a table full or not
// scanning header answers straight from the idle state, without a search. A read
// passes S_RWAIT and S_RREC to its first result, and each further name byte is
// fetched through S_RN and S_RNB after the previous result transfers.
// The block works on one item at a time and holds item ready low from the
// acceptance of a result-giving item until its last result has transferred, so
// a stalled receiver simply holds the result register and the block.
// Reset clears the scan flag, the device count and the parser; the table
// memories need no clearing since only entries below the count are ever used.
module ble_advert_dedup_table import bleadv_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	bleadv_in_if.sink        item,
	bleadv_out_if.source     result
);

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_CMP, S_NEW, S_RWAIT, S_RREC, S_RN, S_RNB
	} state_t;

	typedef enum logic [2:0] {
		PH_OFF, PH_LEN, PH_TYPE, PH_COPY, PH_SKIP
	} phase_t;

	state_t              state_q;
	phase_t              phase_q;
	logic                scan_q;
	logic [COUNT_W-1:0]  count_q;
	logic [7:0]          brem_q;
	logic [7:0]          elem_q;
	logic [SLOT_W-1:0]   target_q;
	logic [NPOS_W-1:0]   pos_q;
	logic [SLOT_W-1:0]   ptr_q;
	logic [NPOS_W-1:0]   k_q;
	logic                out_valid_q;
	out_item_t           out_q;
	logic [47:0]         hdr_addr_q;
	logic [7:0]          hdr_str_q;
	logic [7:0]          hdr_kind_q;
	logic [7:0]          hdr_len_q;

	// Table memories, one read port driven by the shared pointer.
	logic [47:0]         addr_mem [MAX_DEVICES];
	logic [7:0]          str_mem  [MAX_DEVICES];
	logic [7:0]          kind_mem [MAX_DEVICES];
	logic [NPOS_W-1:0]   nlen_mem [MAX_DEVICES];
	logic [7:0]          name_mem [MAX_DEVICES * NAME_ROOM];
	logic [47:0]         addr_rd_q;
	logic [7:0]          str_rd_q;
	logic [7:0]          kind_rd_q;
	logic [NPOS_W-1:0]   nlen_rd_q;
	logic [7:0]          name_rd_q;

	logic                acc;
	in_item_t            in_d;
	logic [7:0]          elem_dec;
	logic                rec_we;
	logic                str_we;
	logic [7:0]          str_wdata;
	logic                nlen_we;
	logic [SLOT_W-1:0]   nlen_wa;
	logic [NPOS_W-1:0]   nlen_wdata;
	logic                name_we;
	logic [NAME_AW-1:0]  name_wa;
	logic [NAME_AW-1:0]  name_ra;
	logic [SLOT_W-1:0]   new_slot;

	assign item.ready   = (state_q == S_IDLE) && !out_valid_q;
	assign acc          = item.valid && item.ready;
	assign in_d         = item.payload;
	assign result.valid = out_valid_q;
	assign result.payload = out_q;
	assign elem_dec     = elem_q - 8'd1;
	assign new_slot     = count_q[SLOT_W-1:0];

	assign name_wa = NAME_AW'(target_q) * NAME_AW'(NAME_ROOM) + NAME_AW'(pos_q);
	assign name_ra = NAME_AW'(ptr_q) * NAME_AW'(NAME_ROOM) + NAME_AW'(k_q);

	// Write strobes for the memories.
	always_comb begin
		rec_we     = (state_q == S_NEW);
		str_we     = 1'b0;
		str_wdata  = hdr_str_q;
		nlen_we    = rec_we;
		nlen_wa    = new_slot;
		nlen_wdata = '0;
		name_we    = 1'b0;
		if (state_q == S_CMP && addr_rd_q == hdr_addr_q &&
				$signed(hdr_str_q) > $signed(str_rd_q)) begin
			str_we = 1'b1;
		end
		if (acc && in_d.action == ACT_DATA && brem_q != 8'd0 && phase_q == PH_COPY) begin
			name_we = (pos_q < NPOS_W'(NAME_ROOM));
			if (elem_dec == 8'd0) begin
				nlen_we    = 1'b1;
				nlen_wa    = target_q;
				nlen_wdata = pos_q + NPOS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			addr_mem[new_slot] <= hdr_addr_q;
			str_mem[new_slot]  <= hdr_str_q;
			kind_mem[new_slot] <= hdr_kind_q;
		end else if (str_we) begin
			str_mem[ptr_q] <= str_wdata;
		end
		if (nlen_we) begin
			nlen_mem[nlen_wa] <= nlen_wdata;
		end
		if (name_we) begin
			name_mem[name_wa] <= in_d.data_byte;
		end
		addr_rd_q <= addr_mem[ptr_q];
		str_rd_q  <= str_mem[ptr_q];
		kind_rd_q <= kind_mem[ptr_q];
		nlen_rd_q <= nlen_mem[ptr_q];
		name_rd_q <= name_mem[name_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_OFF;
			scan_q      <= 1'b0;
			count_q     <= '0;
			brem_q      <= '0;
			elem_q      <= '0;
			target_q    <= '0;
			pos_q       <= '0;
			ptr_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			hdr_addr_q  <= '0;
			hdr_str_q   <= '0;
			hdr_kind_q  <= '0;
			hdr_len_q   <= '0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
				if (!out_q.last) begin
					k_q     <= k_q + NPOS_W'(1);
					state_q <= S_RN;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						out_q <= '0;
						out_q.last <= 1'b1;
						out_q.device_count <= 5'(count_q);
						case (in_d.action)
							ACT_START, ACT_STOP: begin
								scan_q  <= (in_d.action == ACT_START);
								brem_q  <= '0;
								phase_q <= PH_OFF;
								elem_q  <= '0;
								if (in_d.action == ACT_START) begin
									count_q <= '0;
									out_q.device_count <= '0;
								end
								out_q.status <= ST_CTRL;
								out_valid_q  <= 1'b1;
							end
							ACT_HEADER: begin
								brem_q     <= in_d.data_length;
								phase_q    <= PH_OFF;
								elem_q     <= '0;
								hdr_addr_q <= in_d.device_address;
								hdr_str_q  <= in_d.signal_strength;
								hdr_kind_q <= in_d.advert_kind;
								hdr_len_q  <= in_d.data_length;
								ptr_q      <= '0;
								if (!scan_q) begin
									out_q.status <= ST_NOT_SCAN;
									out_valid_q  <= 1'b1;
								end else if (count_q >= COUNT_W'(MAX_DEVICES)) begin
									out_q.status <= ST_FULL;
									out_valid_q  <= 1'b1;
								end else if (count_q == '0) begin
									state_q <= S_NEW;
								end else begin
									state_q <= S_RD;
								end
							end
							ACT_DATA: begin
								if (brem_q != 8'd0) begin
									brem_q <= brem_q - 8'd1;
									case (phase_q)
										PH_LEN: begin
											if (brem_q <= 8'd1 || in_d.data_byte == 8'd0 ||
													in_d.data_byte > brem_q - 8'd1) begin
												phase_q <= PH_OFF;
											end else begin
												elem_q  <= in_d.data_byte;
												phase_q <= PH_TYPE;
											end
										end
										PH_TYPE: begin
											elem_q <= elem_dec;
											if ((in_d.data_byte == AD_SHORT_NAME ||
													in_d.data_byte == AD_FULL_NAME) &&
													elem_dec != 8'd0 &&
													elem_dec < 8'(NAME_BYTES)) begin
												pos_q   <= '0;
												phase_q <= PH_COPY;
											end else if (elem_dec == 8'd0) begin
												phase_q <= PH_LEN;
											end else begin
												phase_q <= PH_SKIP;
											end
										end
										PH_COPY: begin
											pos_q  <= pos_q + NPOS_W'(1);
											elem_q <= elem_dec;
											if (elem_dec == 8'd0) begin
												phase_q <= PH_OFF;
											end
										end
										PH_SKIP: begin
											elem_q <= elem_dec;
											if (elem_dec == 8'd0) begin
												phase_q <= PH_LEN;
											end
										end
										default: begin
										end
									endcase
									// The last announced byte always ends the parse.
									if (brem_q == 8'd1) begin
										phase_q <= PH_OFF;
									end
								end
							end
							ACT_READ: begin
								out_q.entry_slot <= in_d.entry_index;
								if (COUNT_W'(in_d.entry_index) >= count_q) begin
									out_q.status <= ST_BAD_IDX;
									out_valid_q  <= 1'b1;
								end else begin
									ptr_q   <= in_d.entry_index[SLOT_W-1:0];
									k_q     <= '0;
									state_q <= S_RWAIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_RD: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (addr_rd_q == hdr_addr_q) begin
						out_q.status     <= ST_DUP;
						out_q.entry_slot <= 4'(ptr_q);
						out_valid_q      <= 1'b1;
						state_q          <= S_IDLE;
					end else if (COUNT_W'(ptr_q) + COUNT_W'(1) == count_q) begin
						state_q <= S_NEW;
					end else begin
						ptr_q   <= ptr_q + SLOT_W'(1);
						state_q <= S_RD;
					end
				end
				S_NEW: begin
					count_q  <= count_q + COUNT_W'(1);
					target_q <= new_slot;
					pos_q    <= '0;
					phase_q  <= (hdr_len_q != 8'd0) ? PH_LEN : PH_OFF;
					out_q.status       <= ST_NEW;
					out_q.entry_slot   <= 4'(new_slot);
					out_q.device_count <= 5'(count_q + COUNT_W'(1));
					out_valid_q        <= 1'b1;
					state_q            <= S_IDLE;
				end
				S_RWAIT: begin
					state_q <= S_RREC;
				end
				S_RREC: begin
					out_q.status       <= ST_READ;
					out_q.out_address  <= addr_rd_q;
					out_q.out_strength <= str_rd_q;
					out_q.out_kind     <= kind_rd_q;
					out_q.name_length  <= 5'(nlen_rd_q);
					out_q.name_byte    <= (nlen_rd_q == '0) ? 8'd0 : name_rd_q;
					out_q.last         <= (nlen_rd_q <= NPOS_W'(1));
					out_valid_q        <= 1'b1;
					state_q            <= S_IDLE;
				end
				S_RN: begin
					state_q <= S_RNB;
				end
				S_RNB: begin
					out_q.name_byte <= name_rd_q;
					out_q.last      <= (k_q + NPOS_W'(1) == NPOS_W'(out_q.name_length));
					out_valid_q     <= 1'b1;
					state_q         <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* src/bleadv_checker.sv */
// Port-level checks of the duplicate filter, bound to its top level.
module bleadv_checker import bleadv_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic [2:0] in_action,
	input logic      out_valid,
	input logic      out_ready,
	input logic [2:0] out_status,
	input logic [4:0] out_count,
	input logic      out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("item ready while a result is pending");

	a_ctrl_answer: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (in_action == ACT_START || in_action == ACT_STOP)
		|=> out_valid && out_status == ST_CTRL && out_last)
		else $error("start or stop not answered next cycle");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_status != ST_READ |-> out_last)
		else $error("single result without last");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_count <= 5'(MAX_DEVICES))
		else $error("device count beyond table size");

endmodule

bind ble_advert_dedup_table bleadv_checker u_bleadv_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.in_action (item.payload.action),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_status(result.payload.status),
	.out_count (result.payload.device_count),
	.out_last  (result.payload.last)
);
